FILE: sv/yadif_pkg.sv
// Shared types, constants and helper functions of the line filter.
`default_nettype none

package yadif_pkg;

  // Pixel and window geometry.
  localparam int PIXEL_BITS    = 8;
  localparam int WINDOW_RADIUS = 3;
  localparam int WIN_DEPTH     = 2 * WINDOW_RADIUS + 1;
  localparam int WIN_IDX_BITS  = $clog2(WIN_DEPTH);
  localparam int TDEL_DEPTH    = WINDOW_RADIUS + 1;
  localparam int TDEL_IDX_BITS = $clog2(TDEL_DEPTH);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // A direction score is the sum of three absolute differences.
  localparam int SCORE_BITS = PIXEL_BITS + 2;
  // Signed width for pixel differences and the temporal band limits.
  localparam int HD_BITS    = PIXEL_BITS + 2;

  typedef logic [PIXEL_BITS-1:0]        px_t;
  typedef logic [2*PIXEL_BITS-1:0]      px2_t;
  typedef px_t  [WIN_DEPTH-1:0]         win_t;
  typedef logic [SCORE_BITS-1:0]        score_t;
  typedef logic signed [SCORE_BITS:0]   best_t;
  typedef logic signed [HD_BITS-1:0]    hd_t;
  typedef logic [TDEL_IDX_BITS-1:0]     col_t;

  // Temporal inputs of one column.
  typedef struct packed {
    px_t  e_c;
    px_t  l_c;
    px_t  e_up;
    px_t  e_dn;
    px_t  l_up;
    px_t  l_dn;
    px_t  p_a;
    px_t  p_b;
    px_t  n_a;
    px_t  n_b;
    logic skip;
  } tcol_t;

  typedef tcol_t [TDEL_DEPTH-1:0] tdel_t;

  // One column handed from the front to the back.
  typedef struct packed {
    win_t  win_a;
    win_t  win_b;
    px_t   c;
    px_t   e;
    tcol_t t;
    logic  interior;
    logic  line_end;
  } job_t;

  // Front status seen by the top level.
  typedef struct packed {
    logic flushing;
    col_t col_count;
  } front_stat_t;

  function automatic px_t absdiff(px_t a, px_t b);
    px_t r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

  function automatic px_t avg2(px_t a, px_t b);
    logic [PIXEL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIXEL_BITS:1];
  endfunction

  // Score of the direction j around the window centre.
  function automatic score_t dir_score(win_t a, win_t b, int j);
    score_t s;
    s = '0;
    for (int m = -1; m <= 1; m++) begin
      s = s + SCORE_BITS'(absdiff(a[WINDOW_RADIUS + j + m], b[WINDOW_RADIUS - j + m]));
    end
    return s;
  endfunction

  function automatic hd_t to_hd(px_t p);
    return hd_t'({2'b00, p});
  endfunction

  function automatic hd_t smax(hd_t a, hd_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic hd_t smin(hd_t a, hd_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic px_t umax(px_t a, px_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: sv/yadif_front.sv
// Front part: column window, temporal history, line counters and line-end flush.
`default_nettype none

module yadif_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  yadif_pkg::px_t         cur_above,
  input  yadif_pkg::px_t         cur_below,
  input  yadif_pkg::px_t         prev_above,
  input  yadif_pkg::px_t         prev_below,
  input  yadif_pkg::px_t         next_above,
  input  yadif_pkg::px_t         next_below,
  input  yadif_pkg::px_t         early_center,
  input  yadif_pkg::px_t         late_center,
  input  yadif_pkg::px2_t        early_outer,
  input  yadif_pkg::px2_t        late_outer,
  input  logic                   edge_row,
  input  logic                   last_in_line,
  input  logic                   q_full,
  output logic                   q_push,
  output yadif_pkg::job_t        q_job,
  output yadif_pkg::front_stat_t stat
);
  import yadif_pkg::*;

  localparam col_t COL_SAT = col_t'(WINDOW_RADIUS);

  win_t  win_a;
  win_t  win_b;
  tdel_t tdel;
  col_t  col_count;
  col_t  lead_count;
  logic  flushing;
  col_t  flush_idx;

  logic  accept;
  logic  flush_step;
  tcol_t t_new;
  win_t  sh_a;
  win_t  sh_b;
  tdel_t sh_t;
  win_t  src_a;
  win_t  src_b;
  tdel_t src_t;
  col_t  jsel;
  logic [WIN_IDX_BITS-1:0] ci;

  // The front holds off new columns while it flushes a line end or the queue is full.
  assign in_stall   = flushing | q_full;
  assign accept     = in_valid & ~in_stall;
  assign flush_step = flushing & ~q_full;

  // Temporal inputs of the incoming column.
  always_comb begin
    t_new.p_a  = prev_above;
    t_new.p_b  = prev_below;
    t_new.n_a  = next_above;
    t_new.n_b  = next_below;
    t_new.e_c  = early_center;
    t_new.l_c  = late_center;
    t_new.e_up = early_outer[PIXEL_BITS-1:0];
    t_new.e_dn = early_outer[2*PIXEL_BITS-1:PIXEL_BITS];
    t_new.l_up = late_outer[PIXEL_BITS-1:0];
    t_new.l_dn = late_outer[2*PIXEL_BITS-1:PIXEL_BITS];
    t_new.skip = edge_row;
  end

  // Window and history as they stand once the incoming column is shifted in.
  assign sh_a = {cur_above, win_a[WIN_DEPTH-1:1]};
  assign sh_b = {cur_below, win_b[WIN_DEPTH-1:1]};
  assign sh_t = {tdel[TDEL_DEPTH-2:0], t_new};

  // Column selection: the accepting cycle uses the shifted view, flush cycles the stored one.
  always_comb begin
    src_a = flushing ? win_a : sh_a;
    src_b = flushing ? win_b : sh_b;
    src_t = flushing ? tdel  : sh_t;
    if (flushing) begin
      jsel = flush_idx;
    end else if (last_in_line) begin
      jsel = col_count;
    end else begin
      jsel = COL_SAT;
    end
    ci = WIN_IDX_BITS'(WIN_DEPTH - 1) - WIN_IDX_BITS'(jsel);
  end

  // Job towards the back part.
  always_comb begin
    q_job.win_a    = src_a;
    q_job.win_b    = src_b;
    q_job.c        = src_a[ci];
    q_job.e        = src_b[ci];
    q_job.t        = src_t[jsel];
    q_job.interior = ~flushing & (jsel == COL_SAT) & (lead_count == COL_SAT);
    q_job.line_end = (jsel == '0) & (flushing | last_in_line);
    if (flushing) begin
      q_push = flush_step;
    end else begin
      q_push = accept & (last_in_line | (col_count == COL_SAT));
    end
  end

  assign stat.flushing  = flushing;
  assign stat.col_count = col_count;

  // Window, history and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_a      <= '0;
      win_b      <= '0;
      tdel       <= '0;
      col_count  <= '0;
      lead_count <= '0;
      flushing   <= 1'b0;
      flush_idx  <= '0;
    end else if (accept) begin
      tdel <= sh_t;
      if (!last_in_line) begin
        win_a <= sh_a;
        win_b <= sh_b;
        if (col_count == COL_SAT) begin
          if (lead_count != COL_SAT) begin
            lead_count <= lead_count + col_t'(1);
          end
        end else begin
          col_count <= col_count + col_t'(1);
        end
      end else if (col_count == '0) begin
        win_a      <= '0;
        win_b      <= '0;
        lead_count <= '0;
      end else begin
        win_a     <= sh_a;
        win_b     <= sh_b;
        flushing  <= 1'b1;
        flush_idx <= col_count - col_t'(1);
      end
    end else if (flush_step) begin
      if (flush_idx == '0) begin
        flushing   <= 1'b0;
        win_a      <= '0;
        win_b      <= '0;
        col_count  <= '0;
        lead_count <= '0;
      end else begin
        flush_idx <= flush_idx - col_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/yadif_queue.sv
// Short job queue between the front and back parts.
`default_nettype none

module yadif_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  yadif_pkg::job_t   push_job,
  input  logic              pop,
  output yadif_pkg::job_t   head,
  output logic              full,
  output logic              empty
);
  import yadif_pkg::*;

  job_t                      entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full  = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/yadif_back.sv
// Back part: three-stage pipeline for edge search, temporal band and clamping.
`default_nettype none

module yadif_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            temporal_only,
  input  logic            q_empty,
  input  yadif_pkg::job_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output yadif_pkg::px_t  pixel,
  output logic            line_end
);
  import yadif_pkg::*;

  logic   en;

  // Stage one registers.
  logic   s1_valid;
  best_t  s1_base;
  score_t s1_sc_m1;
  score_t s1_sc_m2;
  score_t s1_sc_p1;
  score_t s1_sc_p2;
  px_t    s1_pr_v;
  px_t    s1_pr_m1;
  px_t    s1_pr_m2;
  px_t    s1_pr_p1;
  px_t    s1_pr_p2;
  logic   s1_interior;
  logic   s1_vchk;
  px_t    s1_d;
  px_t    s1_diff;
  px_t    s1_c;
  px_t    s1_e;
  px_t    s1_b;
  px_t    s1_f;
  logic   s1_end;

  // Stage two registers.
  logic   s2_valid;
  px_t    s2_pred;
  px_t    s2_d;
  hd_t    s2_diff;
  logic   s2_end;

  // Stage one combinational values.
  best_t  base_ext;
  px_t    td0;
  px_t    td1;
  px_t    td2;
  logic [PIXEL_BITS:0] sum1;
  logic [PIXEL_BITS:0] sum2;

  // Stage two combinational values.
  best_t  best;
  px_t    pred;
  hd_t    dc;
  hd_t    de;
  hd_t    bc;
  hd_t    fe;
  hd_t    hi;
  hd_t    lo;
  hd_t    diffv;

  // Stage three combinational values.
  hd_t    up;
  hd_t    dn;
  hd_t    pv;
  hd_t    res;

  // The whole pipeline advances unless a finished result is held by the receiver.
  assign en    = ~(out_valid & out_stall);
  assign q_pop = en & ~q_empty;

  // Stage one: direction scores, candidate predictions and temporal terms.
  always_comb begin
    base_ext = best_t'({1'b0, dir_score(q_head.win_a, q_head.win_b, 0)}) - best_t'(1);
    td0  = absdiff(q_head.t.e_c, q_head.t.l_c);
    sum1 = {1'b0, absdiff(q_head.t.p_a, q_head.c)} + {1'b0, absdiff(q_head.t.p_b, q_head.e)};
    sum2 = {1'b0, absdiff(q_head.t.n_a, q_head.c)} + {1'b0, absdiff(q_head.t.n_b, q_head.e)};
    td1  = sum1[PIXEL_BITS:1];
    td2  = sum2[PIXEL_BITS:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= ~q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_base     <= base_ext;
      s1_sc_m1    <= dir_score(q_head.win_a, q_head.win_b, -1);
      s1_sc_m2    <= dir_score(q_head.win_a, q_head.win_b, -2);
      s1_sc_p1    <= dir_score(q_head.win_a, q_head.win_b, 1);
      s1_sc_p2    <= dir_score(q_head.win_a, q_head.win_b, 2);
      s1_pr_v     <= avg2(q_head.c, q_head.e);
      s1_pr_m1    <= avg2(q_head.win_a[WINDOW_RADIUS-1], q_head.win_b[WINDOW_RADIUS+1]);
      s1_pr_m2    <= avg2(q_head.win_a[WINDOW_RADIUS-2], q_head.win_b[WINDOW_RADIUS+2]);
      s1_pr_p1    <= avg2(q_head.win_a[WINDOW_RADIUS+1], q_head.win_b[WINDOW_RADIUS-1]);
      s1_pr_p2    <= avg2(q_head.win_a[WINDOW_RADIUS+2], q_head.win_b[WINDOW_RADIUS-2]);
      s1_interior <= q_head.interior;
      s1_vchk     <= ~temporal_only & ~q_head.t.skip;
      s1_d        <= avg2(q_head.t.e_c, q_head.t.l_c);
      s1_diff     <= umax(umax({1'b0, td0[PIXEL_BITS-1:1]}, td1), td2);
      s1_c        <= q_head.c;
      s1_e        <= q_head.e;
      s1_b        <= avg2(q_head.t.e_up, q_head.t.l_up);
      s1_f        <= avg2(q_head.t.e_dn, q_head.t.l_dn);
      s1_end      <= q_head.line_end;
    end
  end

  // Stage two: direction choice and the vertical check on the temporal band.
  always_comb begin
    best = s1_base;
    pred = s1_pr_v;
    if (s1_interior) begin
      if (best_t'({1'b0, s1_sc_m1}) < best) begin
        best = best_t'({1'b0, s1_sc_m1});
        pred = s1_pr_m1;
        if (best_t'({1'b0, s1_sc_m2}) < best) begin
          best = best_t'({1'b0, s1_sc_m2});
          pred = s1_pr_m2;
        end
      end
      if (best_t'({1'b0, s1_sc_p1}) < best) begin
        best = best_t'({1'b0, s1_sc_p1});
        pred = s1_pr_p1;
        if (best_t'({1'b0, s1_sc_p2}) < best) begin
          pred = s1_pr_p2;
        end
      end
    end
    dc = to_hd(s1_d) - to_hd(s1_c);
    de = to_hd(s1_d) - to_hd(s1_e);
    bc = to_hd(s1_b) - to_hd(s1_c);
    fe = to_hd(s1_f) - to_hd(s1_e);
    hi = smax(smax(de, dc), smin(bc, fe));
    lo = smin(smin(de, dc), smax(bc, fe));
    if (s1_vchk) begin
      diffv = smax(smax(to_hd(s1_diff), lo), -hi);
    end else begin
      diffv = to_hd(s1_diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pred <= pred;
      s2_d    <= s1_d;
      s2_diff <= diffv;
      s2_end  <= s1_end;
    end
  end

  // Stage three: clamp the prediction into the band around the temporal average.
  always_comb begin
    up = to_hd(s2_d) + s2_diff;
    dn = to_hd(s2_d) - s2_diff;
    pv = to_hd(s2_pred);
    if (pv > up) begin
      res = up;
    end else if (pv < dn) begin
      res = dn;
    end else begin
      res = pv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel    <= res[PIXEL_BITS-1:0];
      line_end <= s2_end;
    end
  end

endmodule

`default_nettype wire

FILE: sv/yadif_deinterlace_line_filter.sv
// Top level of the edge-directed, motion-adaptive line filter.
//
// One input transaction carries one pixel column of a missing interlaced line:
// current, previous and next frame pixels on the lines above and below, and the
// earlier and later same-parity field pixels. One output transaction carries one
// interpolated pixel; line_end marks the last pixel of a line. Both channels use
// valid and stall. The configuration channel (cfg_valid, cfg_ready, cfg_data)
// writes temporal_only and is always ready.
// A column yields its pixel three columns later; the first three columns of a
// line yield nothing and the last column of a line flushes every pending pixel.
// Throughput is one column per cycle while the queue has room; the last column
// of a line holds the input while the front flushes the pending columns, one job
// a cycle unless the queue is full. A queued job passes the queue, back-end stage
// one, stage two and the output register before its pixel is valid.
// A four-entry job queue separates input and output, so the input keeps flowing
// for a while when the receiver stalls; the back end freezes as a whole while a
// result waits. Synchronous reset clears the window, the counters, the queue,
// the pipeline and temporal_only.
`default_nettype none

module yadif_deinterlace_line_filter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  yadif_pkg::px_t        cur_above,
  input  yadif_pkg::px_t        cur_below,
  input  yadif_pkg::px_t        prev_above,
  input  yadif_pkg::px_t        prev_below,
  input  yadif_pkg::px_t        next_above,
  input  yadif_pkg::px_t        next_below,
  input  yadif_pkg::px_t        early_center,
  input  yadif_pkg::px_t        late_center,
  input  yadif_pkg::px2_t       early_outer,
  input  yadif_pkg::px2_t       late_outer,
  input  logic                  edge_row,
  input  logic                  last_in_line,
  output logic                  out_valid,
  input  logic                  out_stall,
  output yadif_pkg::px_t        pixel,
  output logic                  line_end
);
  import yadif_pkg::*;

  logic        temporal_only;
  logic        q_push;
  job_t        q_job;
  logic        q_pop;
  job_t        q_head;
  logic        q_full;
  logic        q_empty;
  front_stat_t front_stat;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temporal_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      temporal_only <= cfg_data;
    end
  end

  yadif_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cur_above    (cur_above),
    .cur_below    (cur_below),
    .prev_above   (prev_above),
    .prev_below   (prev_below),
    .next_above   (next_above),
    .next_below   (next_below),
    .early_center (early_center),
    .late_center  (late_center),
    .early_outer  (early_outer),
    .late_outer   (late_outer),
    .edge_row     (edge_row),
    .last_in_line (last_in_line),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job),
    .stat         (front_stat)
  );

  yadif_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  yadif_back u_back (
    .clk           (clk),
    .rst           (rst),
    .temporal_only (temporal_only),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel         (pixel),
    .line_end      (line_end)
  );

`ifndef NO_ASSERTIONS
  // The front never writes a job into a full queue.
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("job pushed into a full queue");

  // The back never takes a job from an empty queue.
  assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("job popped from an empty queue");

  // Once the line-end job is queued the flush is over and the line counter restarts.
  assert property (@(posedge clk) disable iff (rst)
    (q_push && q_job.line_end) |=> (!front_stat.flushing && front_stat.col_count == '0))
    else $error("line end queued but front still flushing");
`endif

endmodule

`default_nettype wire

FILE: tb/yadif_deinterlace_line_filter_tb.sv
// Self-checking testbench of the line filter: directed table, random lines, predictor check.
module yadif_deinterlace_line_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import yadif_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_AT       = 170;
  localparam int HOLD_CYCLES   = 80;
  localparam int REPORT_CAP    = 30;

  // Kinds of random line content.
  typedef enum int {
    STYLE_NOISE,
    STYLE_SMOOTH,
    STYLE_EXTREME,
    STYLE_MOTION
  } line_style_t;

  // Receiver stall patterns.
  typedef enum int {
    RX_OPEN,
    RX_EVERY_THIRD,
    RX_HALF,
    RX_LIGHT
  } rx_mode_t;

  // One input column as offered to the block.
  typedef struct {
    px_t  cur_above;
    px_t  cur_below;
    px_t  prev_above;
    px_t  prev_below;
    px_t  next_above;
    px_t  next_below;
    px_t  early_center;
    px_t  late_center;
    px2_t early_outer;
    px2_t late_outer;
    logic edge_row;
    logic last_in_line;
  } column_t;

  typedef struct {
    px_t  pixel;
    logic line_end;
  } pixel_result_t;

  // Directed row: a column and, where obvious, the pixel all its results must carry.
  typedef struct {
    column_t col;
    bit      typed;
    px_t     px;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  px_t  cur_above = '0;
  px_t  cur_below = '0;
  px_t  prev_above = '0;
  px_t  prev_below = '0;
  px_t  next_above = '0;
  px_t  next_below = '0;
  px_t  early_center = '0;
  px_t  late_center = '0;
  px2_t early_outer = '0;
  px2_t late_outer = '0;
  logic edge_row = 1'b0;
  logic last_in_line = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  px_t  pixel;
  logic line_end;

  yadif_deinterlace_line_filter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cur_above    (cur_above),
    .cur_below    (cur_below),
    .prev_above   (prev_above),
    .prev_below   (prev_below),
    .next_above   (next_above),
    .next_below   (next_below),
    .early_center (early_center),
    .late_center  (late_center),
    .early_outer  (early_outer),
    .late_outer   (late_outer),
    .edge_row     (edge_row),
    .last_in_line (last_in_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel        (pixel),
    .line_end     (line_end)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: window of the current-frame lines and temporal history.
  int    win_above [WIN_DEPTH];
  int    win_below [WIN_DEPTH];
  tcol_t tcol_hist [TDEL_DEPTH];
  int    cols_seen;
  int    lead_seen;
  bit    vcheck_off;

  pixel_result_t expected_pixels[$];
  directed_row_t directed_rows[$];
  int mismatch_count = 0;
  int items_accepted = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int imin(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int clamp_px(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Matching cost of direction j around window centre ci.
  function automatic int dir_cost(int ci, int j);
    return iabs(win_above[ci+j-1] - win_below[ci-1-j])
         + iabs(win_above[ci+j]   - win_below[ci-j])
         + iabs(win_above[ci+j+1] - win_below[ci+1-j]);
  endfunction

  // Interpolated pixel of the column j places behind the newest one.
  function automatic px_t interp_column(int j, bit interior);
    int ci, c, e, d, td0, td1, td2, diff, pred, best, s, b, f, hi, lo;
    tcol_t t;
    ci = WIN_DEPTH - 1 - j;
    t = tcol_hist[j % TDEL_DEPTH];
    c = win_above[ci];
    e = win_below[ci];
    d = (int'(t.e_c) + int'(t.l_c)) >>> 1;
    td0 = iabs(int'(t.e_c) - int'(t.l_c));
    td1 = (iabs(int'(t.p_a) - c) + iabs(int'(t.p_b) - e)) >>> 1;
    td2 = (iabs(int'(t.n_a) - c) + iabs(int'(t.n_b) - e)) >>> 1;
    diff = imax(imax(td0 >>> 1, td1), td2);
    pred = (c + e) >>> 1;

    // Edge-directed search, interior columns only.
    if (interior) begin
      best = iabs(win_above[ci-1] - win_below[ci-1]) + iabs(c - e)
           + iabs(win_above[ci+1] - win_below[ci+1]) - 1;
      s = dir_cost(ci, -1);
      if (s < best) begin
        best = s;
        pred = (win_above[ci-1] + win_below[ci+1]) >>> 1;
        s = dir_cost(ci, -2);
        if (s < best) begin
          best = s;
          pred = (win_above[ci-2] + win_below[ci+2]) >>> 1;
        end
      end
      s = dir_cost(ci, 1);
      if (s < best) begin
        best = s;
        pred = (win_above[ci+1] + win_below[ci-1]) >>> 1;
        s = dir_cost(ci, 2);
        if (s < best) begin
          best = s;
          pred = (win_above[ci+2] + win_below[ci-2]) >>> 1;
        end
      end
    end

    // Vertical spatial check widens the temporal bound.
    if (!vcheck_off && !t.skip) begin
      b = (int'(t.e_up) + int'(t.l_up)) >>> 1;
      f = (int'(t.e_dn) + int'(t.l_dn)) >>> 1;
      hi = imax(imax(d - e, d - c), imin(b - c, f - e));
      lo = imin(imin(d - e, d - c), imax(b - c, f - e));
      diff = imax(imax(diff, lo), -hi);
    end

    if (pred > d + diff)
      pred = d + diff;
    else if (pred < d - diff)
      pred = d - diff;
    return px_t'(pred);
  endfunction

  function automatic void reset_predictor();
    foreach (win_above[i]) begin
      win_above[i] = 0;
      win_below[i] = 0;
    end
    foreach (tcol_hist[i]) tcol_hist[i] = '0;
    cols_seen = 0;
    lead_seen = 0;
    vcheck_off = 1'b0;
  endfunction

  // Advance the predictor by one accepted column and queue the pixels it releases.
  function automatic void predict_column(column_t col, bit typed, px_t typed_px);
    int k, first;
    tcol_t t;
    pixel_result_t r;
    k = cols_seen;
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      win_above[i] = win_above[i+1];
      win_below[i] = win_below[i+1];
    end
    win_above[WIN_DEPTH-1] = int'(col.cur_above);
    win_below[WIN_DEPTH-1] = int'(col.cur_below);

    t.p_a  = col.prev_above;
    t.p_b  = col.prev_below;
    t.n_a  = col.next_above;
    t.n_b  = col.next_below;
    t.e_c  = col.early_center;
    t.l_c  = col.late_center;
    t.e_up = col.early_outer[PIXEL_BITS-1:0];
    t.e_dn = col.early_outer[2*PIXEL_BITS-1:PIXEL_BITS];
    t.l_up = col.late_outer[PIXEL_BITS-1:0];
    t.l_dn = col.late_outer[2*PIXEL_BITS-1:PIXEL_BITS];
    t.skip = col.edge_row;
    for (int i = TDEL_DEPTH - 1; i > 0; i--) tcol_hist[i] = tcol_hist[i-1];
    tcol_hist[0] = t;

    if (!col.last_in_line) begin
      if (k >= 3) begin
        r.pixel = typed ? typed_px : interp_column(3, lead_seen >= 3);
        r.line_end = 1'b0;
        expected_pixels.push_back(r);
        if (lead_seen < 3) lead_seen++;
      end else begin
        cols_seen = k + 1;
      end
    end else begin
      // Line end: flush every pending column, oldest first.
      first = (k >= 3) ? 3 : k;
      for (int i = first; i >= 0; i--) begin
        r.pixel = typed ? typed_px : interp_column(i, (i == 3) && (lead_seen >= 3));
        r.line_end = (i == 0);
        expected_pixels.push_back(r);
      end
      cols_seen = 0;
      lead_seen = 0;
      foreach (win_above[i]) begin
        win_above[i] = 0;
        win_below[i] = 0;
      end
    end
  endfunction

  function automatic column_t make_column(px_t ca, px_t cb, px_t pa, px_t pb, px_t na,
                                          px_t nb, px_t ec, px_t lc, px2_t eo, px2_t lo,
                                          logic er, logic last);
    column_t col;
    col.cur_above    = ca;
    col.cur_below    = cb;
    col.prev_above   = pa;
    col.prev_below   = pb;
    col.next_above   = na;
    col.next_below   = nb;
    col.early_center = ec;
    col.late_center  = lc;
    col.early_outer  = eo;
    col.late_outer   = lo;
    col.edge_row     = er;
    col.last_in_line = last;
    return col;
  endfunction

  function automatic void add_row(column_t col, bit typed, px_t px);
    directed_row_t row;
    row.col = col;
    row.typed = typed;
    row.px = px;
    directed_rows.push_back(row);
  endfunction

  function automatic px_t pick_px(line_style_t style, int base);
    int v;
    case (style)
      STYLE_NOISE:   v = $urandom_range(0, 255);
      STYLE_SMOOTH:  v = base + int'($urandom_range(0, 24)) - 12;
      STYLE_EXTREME: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
      default:       v = base + int'($urandom_range(0, 120)) - 60;
    endcase
    return px_t'(clamp_px(v));
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < REPORT_CAP)
      $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Offer one column and hold it until the block takes it.
  task automatic send_column(column_t col, bit typed, px_t typed_px);
    cur_above    <= col.cur_above;
    cur_below    <= col.cur_below;
    prev_above   <= col.prev_above;
    prev_below   <= col.prev_below;
    next_above   <= col.next_above;
    next_below   <= col.next_below;
    early_center <= col.early_center;
    late_center  <= col.late_center;
    early_outer  <= col.early_outer;
    late_outer   <= col.late_outer;
    edge_row     <= col.edge_row;
    last_in_line <= col.last_in_line;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_accepted++;
    predict_column(col, typed, typed_px);
  endtask

  // Bursts of random length separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every expected pixel, then let the pipeline settle.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_temporal_only(bit v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vcheck_off = v;
  endtask

  // Random complete lines until at least target columns have gone in.
  task automatic run_random_lines(int target);
    int sent, len, r, edge_mode, base_a, base_b, base_m;
    line_style_t style;
    column_t col;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 19);
      len = (r < 15) ? $urandom_range(1, 10) : (r < 19) ? $urandom_range(11, 24)
                                                        : $urandom_range(25, 48);
      r = $urandom_range(0, 19);
      style = (r < 6) ? STYLE_NOISE : (r < 12) ? STYLE_SMOOTH
            : (r < 15) ? STYLE_EXTREME : STYLE_MOTION;
      edge_mode = $urandom_range(0, 3);
      base_a = $urandom_range(0, 255);
      base_b = ($urandom_range(0, 1) != 0) ? base_a : $urandom_range(0, 255);
      for (int i = 0; i < len; i++) begin
        base_a = clamp_px(base_a + int'($urandom_range(0, 16)) - 8);
        base_b = clamp_px(base_b + int'($urandom_range(0, 16)) - 8);
        base_m = (base_a + base_b) / 2;
        col.cur_above    = pick_px(style, base_a);
        col.cur_below    = pick_px(style, base_b);
        col.prev_above   = pick_px(style, base_a);
        col.prev_below   = pick_px(style, base_b);
        col.next_above   = pick_px(style, base_a);
        col.next_below   = pick_px(style, base_b);
        col.early_center = pick_px(style, base_m);
        col.late_center  = pick_px(style, base_m);
        col.early_outer  = {pick_px(style, base_b), pick_px(style, base_a)};
        col.late_outer   = {pick_px(style, base_b), pick_px(style, base_a)};
        col.edge_row     = (edge_mode == 0) ? 1'b0 : (edge_mode == 1) ? 1'b1
                                                   : 1'($urandom_range(0, 1));
        col.last_in_line = (i == len - 1);
        send_column(col, 1'b0, '0);
        pace_sender();
        sent++;
      end
    end
  endtask

  // Result checker: every output transaction against the oldest expectation.
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %0d line_end %0b", pixel, line_end));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel !== want.pixel)
          report_mismatch($sformatf("pixel %0d, expected %0d", pixel, want.pixel));
        if (line_end !== want.line_end)
          report_mismatch($sformatf("line_end %0b, expected %0b", line_end, want.line_end));
      end
    end
  end

  // Receiver: stall patterns of its own, plus one long hold-off.
  initial begin : receiver
    int seg_left, hold, tick;
    bit hold_done;
    rx_mode_t mode;
    seg_left = 0;
    hold = 0;
    tick = 0;
    hold_done = 1'b0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk);
      if (!hold_done && items_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        tick++;
        case (mode)
          RX_OPEN:        out_stall <= 1'b0;
          RX_EVERY_THIRD: out_stall <= (tick % 3 == 0);
          RX_HALF:        out_stall <= ($urandom_range(0, 1) != 0);
          default:        out_stall <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** yadif_deinterlace_line_filter: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence.
  initial begin : stimulus
    px_t pat_a [8];
    px_t pat_b [8];
    pat_a = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    pat_b = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    reset_predictor();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    // Single-column line straight after reset: all zero in, zero out.
    add_row(make_column(0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0, 1), 1, 8'd0);
    // Four-column line, all inputs at full scale: every pixel at full scale.
    for (int i = 0; i < 4; i++)
      add_row(make_column(255, 255, 255, 255, 255, 255, 255, 255, 16'hFFFF, 16'hFFFF, 0,
                          i == 3), 1, 8'd255);
    // Short line of opposite extremes, edge row set.
    add_row(make_column(255, 0, 0, 255, 255, 0, 0, 255, 16'hFF00, 16'h00FF, 1, 0), 0, 0);
    add_row(make_column(0, 255, 255, 0, 0, 255, 255, 0, 16'h00FF, 16'hFF00, 1, 1), 0, 0);
    // Eight columns with a diagonal edge: interior columns use the direction search.
    for (int i = 0; i < 8; i++)
      add_row(make_column(pat_a[i], pat_b[i], pat_a[i], pat_b[i], 8'd255 - pat_a[i], pat_b[i],
                          (i % 2 != 0) ? 8'd255 : 8'd0, (i % 3 == 0) ? 8'd255 : 8'd0,
                          (i % 2 != 0) ? 16'hFFFF : 16'h00FF,
                          (i % 2 != 0) ? 16'h0000 : 16'hFF00, 0, i == 7), 0, 0);
    // Three-column line on an edge row.
    for (int i = 0; i < 3; i++)
      add_row(make_column(8'(40 + 60 * i), 8'(200 - 50 * i), 8'd128, 8'd1, 8'd254, 8'd128,
                          8'(10 * i), 8'd250, 16'h8001, 16'h7FFE, 1, i == 2), 0, 0);
    // Six-column line: edge columns only, edge row toggling.
    for (int i = 0; i < 6; i++)
      add_row(make_column(8'(1 + 50 * i), 8'(254 - 40 * i), 8'(30 * i), 8'(255 - 30 * i),
                          8'(7 * i), 8'(100 + 20 * i), 8'(128 + 20 * i), 8'(128 - 20 * i),
                          16'(16'h1234 * (i + 1)), 16'(16'hA5C3 ^ (i * 16'h1111)),
                          1'(i % 2), i == 5), 0, 0);

    write_temporal_only(1'b0);
    foreach (directed_rows[i]) begin
      send_column(directed_rows[i].col, directed_rows[i].typed, directed_rows[i].px);
      pace_sender();
    end
    drain_pixels();

    // Random phases, switching the vertical check between them.
    write_temporal_only(1'b1);
    run_random_lines(110);
    drain_pixels();

    write_temporal_only(1'b0);
    run_random_lines(110);
    drain_pixels();

    write_temporal_only(1'b1);
    run_random_lines(100);
    drain_pixels();

    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("** yadif_deinterlace_line_filter: PASSED **");
    end else begin
      $display("** yadif_deinterlace_line_filter: FAILED **");
    end
    $finish;
  end

endmodule
